FILE: hw/rtl/mse_pkg.sv
// mse_pkg: shared types and constants of the merge sort engine
// holds the controller state encoding and the command/status structs
// no dependencies
package mse_pkg;

    // width of the value fields on the ports
    localparam int FIELD_BITS = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS_CHECK,
        ST_SETUP,
        ST_RD_LEFT,
        ST_RD_RIGHT,
        ST_CAPTURE,
        ST_MERGE,
        ST_SEG_NEXT,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_OUT_WAIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // input beat accepted
        logic start;     // that beat was the last of the list
        logic setup;     // compute bounds of the next pair of runs
        logic rd_left;   // fetch head of left run
        logic rd_right;  // take left head, fetch head of right run
        logic capture;   // take fetched head
        logic merge;     // write smaller head, fetch its successor
        logic seg_next;  // advance to next pair of runs
        logic pass_end;  // swap buffers, double run width
        logic out_rd;    // fetch next sorted element
        logic out_cap;   // load output register
        logic done;      // list delivered, clear count and drop flag
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic w_ge_n;      // run width covers whole list
        logic merge_done;  // this merge step writes the last slot of the pair
        logic last_seg;    // current pair is the last one of the pass
        logic out_final;   // output register holds the final element
    } stat_t;

endpackage

FILE: hw/rtl/mse_ram.sv
// mse_ram: generic single write port, single read port RAM with registered read
// no dependencies
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/mse_ctrl.sv
// mse_ctrl: state machine of the merge sort engine
// sequences loading, bottom-up merge passes and output; depends on mse_pkg
module mse_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_last,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output mse_pkg::cmd_t   cmd,
    input  mse_pkg::stat_t  stat
);

    mse_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mse_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            mse_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last) begin
                        cmd.start  = 1'b1;
                        state_next = mse_pkg::ST_PASS_CHECK;
                    end
                end
            end
            mse_pkg::ST_PASS_CHECK: begin
                state_next = stat.w_ge_n ? mse_pkg::ST_OUT_RD : mse_pkg::ST_SETUP;
            end
            mse_pkg::ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = mse_pkg::ST_RD_LEFT;
            end
            mse_pkg::ST_RD_LEFT: begin
                cmd.rd_left = 1'b1;
                state_next  = mse_pkg::ST_RD_RIGHT;
            end
            mse_pkg::ST_RD_RIGHT: begin
                cmd.rd_right = 1'b1;
                state_next   = mse_pkg::ST_CAPTURE;
            end
            mse_pkg::ST_CAPTURE: begin
                cmd.capture = 1'b1;
                state_next  = mse_pkg::ST_MERGE;
            end
            mse_pkg::ST_MERGE: begin
                cmd.merge  = 1'b1;
                state_next = stat.merge_done ? mse_pkg::ST_SEG_NEXT : mse_pkg::ST_CAPTURE;
            end
            mse_pkg::ST_SEG_NEXT: begin
                if (stat.last_seg) begin
                    cmd.pass_end = 1'b1;
                    state_next   = mse_pkg::ST_PASS_CHECK;
                end else begin
                    cmd.seg_next = 1'b1;
                    state_next   = mse_pkg::ST_SETUP;
                end
            end
            mse_pkg::ST_OUT_RD: begin
                cmd.out_rd = 1'b1;
                state_next = mse_pkg::ST_OUT_CAP;
            end
            mse_pkg::ST_OUT_CAP: begin
                cmd.out_cap = 1'b1;
                state_next  = mse_pkg::ST_OUT_WAIT;
            end
            mse_pkg::ST_OUT_WAIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (stat.out_final) begin
                        cmd.done   = 1'b1;
                        state_next = mse_pkg::ST_LOAD;
                    end else begin
                        cmd.out_rd = 1'b1;
                        state_next = mse_pkg::ST_OUT_CAP;
                    end
                end
            end
            default: begin
                state_next = mse_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

FILE: hw/rtl/mse_datapath.sv
// mse_datapath: element buffers, run bounds, merge compare and output register
// ping-pong pair of mse_ram instances; depends on mse_pkg and mse_ram
module mse_datapath #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  mse_pkg::cmd_t                          cmd,
    output mse_pkg::stat_t                         stat,
    input  logic signed [mse_pkg::FIELD_BITS-1:0]  in_value,
    output logic signed [mse_pkg::FIELD_BITS-1:0]  out_value,
    output logic                                   out_final,
    output logic                                   out_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = CW + 2;
    localparam int FB = mse_pkg::FIELD_BITS;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    // control state
    logic [CW-1:0] cnt_reg;
    logic          drop_reg;
    logic          sel_reg;   // 0: buffer a holds the current runs

    // merge bookkeeping
    logic [CW:0]   w_reg;
    logic [CW-1:0] base_reg, li_reg, le_reg, ri_reg, re_reg, wi_reg, oidx_reg;
    logic          tgt_reg;   // 0: fetched word goes to left head
    logic [VALUE_BITS-1:0] lh_reg, rh_reg, out_val_reg;
    logic          out_final_reg;

    logic [VALUE_BITS-1:0] in_val, pick, rdata, rdata_a, rdata_b, wdata;
    logic [XW-1:0] base_x, w_x, cnt_x, lend_x, rend_x;
    logic [CW-1:0] le_new, re_new, rd_idx;
    logic [AW-1:0] raddr, waddr;
    logic          left_avail, right_avail, take_left, store_ok;
    logic          src_we, dst_we, we_a, we_b;

    // port value to internal width
    if (VALUE_BITS > FB) begin : g_in_wide
        assign in_val    = {{(VALUE_BITS - FB){1'b0}}, in_value};
        assign out_value = out_val_reg[FB-1:0];
    end else if (VALUE_BITS == FB) begin : g_in_same
        assign in_val    = in_value;
        assign out_value = out_val_reg;
    end else begin : g_in_narrow
        assign in_val    = in_value[VALUE_BITS-1:0];
        assign out_value = {{(FB - VALUE_BITS){1'b0}}, out_val_reg};
    end

    // run bounds of the current pair
    always_comb begin
        base_x = XW'(base_reg);
        w_x    = XW'(w_reg);
        cnt_x  = XW'(cnt_reg);
        lend_x = base_x + w_x;
        rend_x = base_x + (w_x << 1);
        le_new = (lend_x < cnt_x) ? lend_x[CW-1:0] : cnt_reg;
        re_new = (rend_x < cnt_x) ? rend_x[CW-1:0] : cnt_reg;
    end

    // merge compare, left wins ties
    assign left_avail  = li_reg < le_reg;
    assign right_avail = ri_reg < re_reg;
    assign take_left   = left_avail &&
                         (!right_avail || ($signed(lh_reg) <= $signed(rh_reg)));
    assign pick        = take_left ? lh_reg : rh_reg;
    assign store_ok    = cnt_reg < MAX_CNT;

    // read address select
    always_comb begin
        priority if (cmd.rd_left) begin
            rd_idx = li_reg;
        end else if (cmd.rd_right) begin
            rd_idx = ri_reg;
        end else if (cmd.merge) begin
            rd_idx = take_left ? (li_reg + CW'(1)) : (ri_reg + CW'(1));
        end else begin
            rd_idx = oidx_reg;
        end
    end
    assign raddr = rd_idx[AW-1:0];

    // loading writes the current buffer, merging writes the other one
    assign src_we = cmd.load && store_ok;
    assign dst_we = cmd.merge;
    assign we_a   = sel_reg ? dst_we : src_we;
    assign we_b   = sel_reg ? src_we : dst_we;
    assign waddr  = cmd.load ? cnt_reg[AW-1:0] : wi_reg[AW-1:0];
    assign wdata  = cmd.load ? in_val : pick;
    assign rdata  = sel_reg ? rdata_b : rdata_a;

    mse_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_ram_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    mse_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_ram_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    // count, drop flag and buffer select
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end else begin
            if (cmd.done) begin
                cnt_reg  <= '0;
                drop_reg <= 1'b0;
            end else if (cmd.load) begin
                if (store_ok) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end else begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.pass_end) begin
                sel_reg <= ~sel_reg;
            end
        end
    end

    // merge indices, heads and output register
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            w_reg    <= (CW + 1)'(1);
            base_reg <= '0;
            oidx_reg <= '0;
        end
        if (cmd.setup) begin
            le_reg <= le_new;
            re_reg <= re_new;
            li_reg <= base_reg;
            ri_reg <= le_new;
            wi_reg <= base_reg;
        end
        if (cmd.rd_left) begin
            tgt_reg <= 1'b0;
        end
        if (cmd.rd_right || cmd.capture) begin
            if (tgt_reg) begin
                rh_reg <= rdata;
            end else begin
                lh_reg <= rdata;
            end
        end
        if (cmd.rd_right) begin
            tgt_reg <= 1'b1;
        end
        if (cmd.merge) begin
            wi_reg <= wi_reg + CW'(1);
            if (take_left) begin
                li_reg  <= li_reg + CW'(1);
                tgt_reg <= 1'b0;
            end else begin
                ri_reg  <= ri_reg + CW'(1);
                tgt_reg <= 1'b1;
            end
        end
        if (cmd.seg_next) begin
            base_reg <= rend_x[CW-1:0];
        end
        if (cmd.pass_end) begin
            w_reg    <= w_reg << 1;
            base_reg <= '0;
        end
        if (cmd.out_rd) begin
            oidx_reg <= oidx_reg + CW'(1);
        end
        if (cmd.out_cap) begin
            out_val_reg   <= rdata;
            out_final_reg <= (oidx_reg == cnt_reg);
        end
    end

    // status to controller
    assign stat.w_ge_n     = w_x >= cnt_x;
    assign stat.last_seg   = rend_x >= cnt_x;
    assign stat.merge_done = (XW'(wi_reg) + XW'(1)) == XW'(re_reg);
    assign stat.out_final  = out_final_reg;

    assign out_final    = out_final_reg;
    assign out_overflow = drop_reg;

    // the store never holds more than its capacity
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_CNT)
        else $error("element count beyond capacity");

    // a merge step always has a head to take
    a_merge_src: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.merge |-> (left_avail || right_avail))
        else $error("merge step with both runs empty");

    // a merge step writes inside its own pair of runs
    a_merge_dst: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.merge |-> (wi_reg < re_reg && wi_reg >= base_reg))
        else $error("merge write outside the pair");

    // output never reads past the loaded elements
    a_out_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_rd |-> (oidx_reg < cnt_reg))
        else $error("output read past list end");

    // each pass doubles the run width
    a_pass_w: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pass_end |=> (w_reg == ($past(w_reg) << 1)))
        else $error("run width not doubled at pass end");

endmodule

FILE: hw/rtl/merge_sort_engine.sv
// merge_sort_engine: loads a list one beat per cycle, then sorts it ascending
// by bottom-up stable merge sort over two buffers and streams it out.
// The sort makes ceil(log2 n) merge passes, each pass doubling the run width.
// The merge loop alternates the capture and merge states (single read port, registered
// read). s_ready is high only while loading, so no new list is accepted until the
// last result has been taken; results are sent as m_ready takes them.
// Reset (aresetn, synchronous, active low) empties the list and clears the drop flag.
module merge_sort_engine #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [mse_pkg::FIELD_BITS-1:0] s_value,
    input  logic                                  s_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [mse_pkg::FIELD_BITS-1:0] m_sorted_value,
    output logic                                  m_final_res,
    output logic                                  m_overflow
);

    mse_pkg::cmd_t  cmd;
    mse_pkg::stat_t stat;

    // sequencing
    mse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // storage and compare
    mse_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_value     (s_value),
        .out_value    (m_sorted_value),
        .out_final    (m_final_res),
        .out_overflow (m_overflow)
    );

endmodule
